/* hdl/ibm_pkg.sv */
// Shared types and constants for the I2C bit-bang master.
// Holds the transaction payload structs and the sequencer codes. No dependencies.
`default_nettype none

package ibm_pkg;

   // item kinds
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_LOAD  = 2'd1;
   localparam logic [1:0] KIND_START = 2'd2;

   localparam logic [3:0] RETRY_RESET = 4'd10;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] device_address;
      logic [7:0] start_address;
      logic [3:0] byte_count;
      logic       is_read;
      logic [7:0] write_byte;
      logic       sda_sample;
   } req_type;

   typedef struct packed {
      logic       scl_drive_low;
      logic       sda_drive_low;
      logic [7:0] read_data;
      logic       read_valid;
      logic       busy_res;
      logic       done_res;
      logic       success;
   } rsp_type;

   typedef enum logic [4:0] {
      PH_IDLE = 5'd0,
      PH_ST0  = 5'd1,
      PH_ST1  = 5'd2,
      PH_ST2  = 5'd3,
      PH_ST3  = 5'd4,
      PH_TB0  = 5'd5,
      PH_TB1  = 5'd6,
      PH_TB2  = 5'd7,
      PH_TA0  = 5'd8,
      PH_TA1  = 5'd9,
      PH_TA2  = 5'd10,
      PH_RXH  = 5'd11,
      PH_RXL  = 5'd12,
      PH_RK0  = 5'd13,
      PH_RK1  = 5'd14,
      PH_RK2  = 5'd15,
      PH_SP0  = 5'd16,
      PH_SP1  = 5'd17,
      PH_SP2  = 5'd18
   } phase_type;

   typedef enum logic [1:0] {
      ROLE_SEL  = 2'd0,
      ROLE_ADR  = 2'd1,
      ROLE_DATA = 2'd2,
      ROLE_RSEL = 2'd3
   } role_type;

endpackage

`default_nettype wire

/* hdl/ibm_seq.sv */
// Bus sequencer: one step per accepted transaction, plus the write byte buffer.
// Depends on ibm_pkg.
`default_nettype none

module ibm_seq
   import ibm_pkg::*;
#(
   parameter int BUFFER_DEPTH = 8
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_accept,
   input  wire req_type req_data,
   input  wire logic [3:0] retry_limit,
   output rsp_type      rsp_next
);

   localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

   phase_type  phase_ff, phase_in;
   role_type   role_ff, role_in;
   logic [3:0] bit_cnt_ff, bit_cnt_in;
   logic [7:0] shift_ff, shift_in;
   logic [3:0] bytes_left_ff, bytes_left_in;
   logic [3:0] attempts_ff, attempts_in;
   logic [7:0] dev_ff, dev_in;
   logic [7:0] reg_ff, reg_in;
   logic       rd_ff, rd_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] next_idx_ff, next_idx_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;

   logic [7:0] wbuf_mem [BUFFER_DEPTH];
   logic [7:0] buf_q_ff;
   logic       mem_we;

   logic [3:0] cnt;
   logic       ack;
   logic [3:0] bit_cnt_inc;
   logic [3:0] bytes_dec;
   logic [3:0] attempts_dec;

   always_comb begin
      phase_in      = phase_ff;
      role_in       = role_ff;
      bit_cnt_in    = bit_cnt_ff;
      shift_in      = shift_ff;
      bytes_left_in = bytes_left_ff;
      attempts_in   = attempts_ff;
      dev_in        = dev_ff;
      reg_in        = reg_ff;
      rd_in         = rd_ff;
      fill_in       = fill_ff;
      next_idx_in   = next_idx_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      mem_we        = 1'b0;
      rsp_next      = '0;

      cnt          = req_data.byte_count;
      ack          = ~req_data.sda_sample;
      bit_cnt_inc  = bit_cnt_ff + 4'd1;
      bytes_dec    = bytes_left_ff - 4'd1;
      attempts_dec = attempts_ff - 4'd1;

      if (req_accept) begin
         unique case (req_data.kind)
            KIND_LOAD: begin
               if (phase_ff == PH_IDLE && fill_ff < CNT_W'(BUFFER_DEPTH)) begin
                  mem_we  = 1'b1;
                  fill_in = fill_ff + CNT_W'(1);
               end
            end
            KIND_START: begin
               if (phase_ff == PH_IDLE) begin
                  fill_in = '0;
                  dev_in  = req_data.device_address;
                  reg_in  = req_data.start_address;
                  rd_in   = req_data.is_read;
                  // write counts saturate at the buffer depth
                  if (!req_data.is_read && int'(cnt) > BUFFER_DEPTH) begin
                     cnt = 4'(BUFFER_DEPTH);
                  end
                  bytes_left_in = cnt;
                  if (cnt == 4'd0) begin
                     rsp_next.done_res = 1'b1;
                  end else begin
                     attempts_in = (retry_limit == 4'd0) ? 4'd1 : retry_limit;
                     role_in     = ROLE_SEL;
                     next_idx_in = '0;
                     phase_in    = PH_ST0;
                  end
               end
            end
            KIND_TICK: begin
               unique case (phase_ff)
                  PH_ST0: begin sda_in = 1'b0; phase_in = PH_ST1; end
                  PH_ST1: begin scl_in = 1'b0; phase_in = PH_ST2; end
                  PH_ST2: begin sda_in = 1'b1; phase_in = PH_ST3; end
                  PH_ST3: begin
                     scl_in     = 1'b1;
                     shift_in   = (role_ff == ROLE_RSEL) ? (dev_ff | 8'h01) : dev_ff;
                     bit_cnt_in = 4'd0;
                     phase_in   = PH_TB0;
                  end
                  PH_TB0: begin
                     scl_in   = 1'b1;
                     sda_in   = ~shift_ff[7];
                     phase_in = PH_TB1;
                  end
                  PH_TB1: begin scl_in = 1'b0; phase_in = PH_TB2; end
                  PH_TB2: begin
                     scl_in     = 1'b1;
                     shift_in   = {shift_ff[6:0], 1'b0};
                     bit_cnt_in = bit_cnt_inc;
                     phase_in   = (bit_cnt_inc >= 4'd8) ? PH_TA0 : PH_TB0;
                  end
                  PH_TA0: begin sda_in = 1'b0; phase_in = PH_TA1; end
                  PH_TA1: begin scl_in = 1'b0; phase_in = PH_TA2; end
                  PH_TA2: begin
                     scl_in = 1'b1;
                     // acknowledge handling, by byte role
                     priority if (role_ff == ROLE_SEL) begin
                        if (ack) begin
                           role_in    = ROLE_ADR;
                           shift_in   = reg_ff;
                           bit_cnt_in = 4'd0;
                           phase_in   = PH_TB0;
                        end else begin
                           attempts_in = attempts_dec;
                           phase_in    = (attempts_dec != 4'd0) ? PH_ST0 : PH_SP0;
                        end
                     end else if (!ack) begin
                        phase_in = PH_SP0;
                     end else if (role_ff == ROLE_ADR) begin
                        if (rd_ff) begin
                           role_in  = ROLE_RSEL;
                           phase_in = PH_ST0;
                        end else begin
                           role_in     = ROLE_DATA;
                           shift_in    = buf_q_ff;
                           bit_cnt_in  = 4'd0;
                           next_idx_in = next_idx_ff + CNT_W'(1);
                           phase_in    = PH_TB0;
                        end
                     end else if (role_ff == ROLE_DATA) begin
                        bytes_left_in = bytes_dec;
                        if (bytes_dec == 4'd0) begin
                           phase_in = PH_SP0;
                        end else begin
                           shift_in    = buf_q_ff;
                           bit_cnt_in  = 4'd0;
                           next_idx_in = next_idx_ff + CNT_W'(1);
                           phase_in    = PH_TB0;
                        end
                     end else begin
                        shift_in   = 8'h00;
                        bit_cnt_in = 4'd0;
                        phase_in   = PH_RXH;
                     end
                  end
                  PH_RXH: begin
                     scl_in   = 1'b0;
                     sda_in   = 1'b0;
                     phase_in = PH_RXL;
                  end
                  PH_RXL: begin
                     scl_in     = 1'b1;
                     shift_in   = {shift_ff[6:0], req_data.sda_sample};
                     bit_cnt_in = bit_cnt_inc;
                     if (bit_cnt_inc >= 4'd8) begin
                        bytes_left_in = bytes_dec;
                        phase_in      = PH_RK0;
                     end else begin
                        phase_in = PH_RXH;
                     end
                  end
                  PH_RK0: begin
                     sda_in   = (bytes_left_ff != 4'd0);
                     phase_in = PH_RK1;
                  end
                  PH_RK1: begin scl_in = 1'b0; phase_in = PH_RK2; end
                  PH_RK2: begin
                     scl_in              = 1'b1;
                     sda_in              = 1'b0;
                     rsp_next.read_data  = shift_ff;
                     rsp_next.read_valid = 1'b1;
                     if (bytes_left_ff == 4'd0) begin
                        phase_in = PH_SP0;
                     end else begin
                        shift_in   = 8'h00;
                        bit_cnt_in = 4'd0;
                        phase_in   = PH_RXH;
                     end
                  end
                  PH_SP0: begin
                     scl_in   = 1'b1;
                     sda_in   = 1'b1;
                     phase_in = PH_SP1;
                  end
                  PH_SP1: begin scl_in = 1'b0; phase_in = PH_SP2; end
                  PH_SP2: begin
                     sda_in            = 1'b0;
                     rsp_next.done_res = 1'b1;
                     rsp_next.success  = (bytes_left_ff == 4'd0);
                     phase_in          = PH_IDLE;
                  end
                  default: begin
                     // idle, and codes with no meaning
                     scl_in   = 1'b0;
                     sda_in   = 1'b0;
                     phase_in = PH_IDLE;
                  end
               endcase
            end
            default: begin
               // kind 3: no effect
            end
         endcase
      end

      rsp_next.scl_drive_low = scl_in;
      rsp_next.sda_drive_low = sda_in;
      rsp_next.busy_res      = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         role_ff       <= ROLE_SEL;
         bit_cnt_ff    <= '0;
         shift_ff      <= '0;
         bytes_left_ff <= '0;
         attempts_ff   <= '0;
         dev_ff        <= '0;
         reg_ff        <= '0;
         rd_ff         <= 1'b0;
         fill_ff       <= '0;
         next_idx_ff   <= '0;
         scl_ff        <= 1'b0;
         sda_ff        <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         role_ff       <= role_in;
         bit_cnt_ff    <= bit_cnt_in;
         shift_ff      <= shift_in;
         bytes_left_ff <= bytes_left_in;
         attempts_ff   <= attempts_in;
         dev_ff        <= dev_in;
         reg_ff        <= reg_in;
         rd_ff         <= rd_in;
         fill_ff       <= fill_in;
         next_idx_ff   <= next_idx_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
      end
   end

   // write buffer; the read port prefetches the next byte to send
   always_ff @(posedge clock) begin
      if (mem_we) begin
         wbuf_mem[fill_ff[IDX_W-1:0]] <= req_data.write_byte;
      end
      buf_q_ff <= wbuf_mem[next_idx_in[IDX_W-1:0]];
   end

   // receive phases only occur in read transactions
   a_rx_is_read: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_RXH || phase_ff == PH_RXL || phase_ff == PH_RK0) |-> rd_ff)
      else $error("receive phase in write transaction");

   // a bit is sent only while fewer than eight have gone out
   a_tx_bits: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_TB0 || phase_ff == PH_TB1) |-> (bit_cnt_ff < 4'd8))
      else $error("bit counter overrun");

   // stop sequence runs to completion once entered
   a_stop_seq: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SP1) |=> (phase_ff == PH_SP1 || phase_ff == PH_SP2))
      else $error("stop sequence broken");

endmodule

`default_nettype wire

/* hdl/ibm_rsp_buf.sv */
// Two-entry result buffer between the sequencer and the result channel.
// Depends on ibm_pkg.
`default_nettype none

module ibm_rsp_buf
   import ibm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   output logic      full,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output rsp_type   rsp_data
);

   rsp_type    slot0_ff, slot0_in;
   rsp_type    slot1_ff, slot1_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slot0_ff;
   assign full      = (count_ff == 2'd2);
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      unique case ({push, pop})
         2'b11: begin
            slot0_in = push_data;
         end
         2'b01: begin
            slot0_in = slot1_ff;
            count_in = count_ff - 2'd1;
         end
         2'b10: begin
            if (count_ff == 2'd0) begin
               slot0_in = push_data;
            end else begin
               slot1_in = push_data;
            end
            count_in = count_ff + 2'd1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer count out of range");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full result buffer");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (full && !pop) |=> full)
      else $error("full buffer lost an entry");

endmodule

`default_nettype wire

/* hdl/i2c_bitbang_master.sv */
// Top level of the pin-level I2C master: sequencer plus result buffer.
// Depends on ibm_pkg, ibm_seq and ibm_rsp_buf.
//
//   channel   dir  handshake          payload
//   req_      in   req_valid/stall    req_type  (tick, load byte, start)
//   rsp_      out  rsp_valid/stall    rsp_type  (line drives, read byte, status)
//   csr_      in   csr_valid/ready    retry_limit, 4 bits
//
// One transaction per clock on the request side while req_stall is low. Each
// accepted request is processed by the sequencer in that cycle and its result
// is registered into a two-entry buffer, from which it is presented. req_stall
// rises only when both buffer entries are held by a stalled result channel.
// Reset (synchronous, active high) idles the bus, releases both lines,
// empties the buffer and sets retry_limit to 10. Buffer contents are not
// cleared; a write that sends unloaded bytes is undefined.
`default_nettype none

module i2c_bitbang_master
   import ibm_pkg::*;
#(
   parameter int BUFFER_DEPTH = 8
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // request channel
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire req_type    req_data,
   // result channel
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_data,
   // control register write
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [3:0] csr_data
);

   logic       req_accept;
   logic       buf_full;
   rsp_type    rsp_next;
   logic [3:0] retry_ff;

   // registers are always writable; software writes only when idle
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_ff <= RETRY_RESET;
      end else if (csr_valid && csr_ready) begin
         retry_ff <= csr_data;
      end
   end

   // stall only when no buffer space is left for the next result
   assign req_stall  = buf_full;
   assign req_accept = req_valid && !req_stall;

   ibm_seq #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_accept  (req_accept),
      .req_data    (req_data),
      .retry_limit (retry_ff),
      .rsp_next    (rsp_next)
   );

   ibm_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (rsp_next),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking bench for i2c_bitbang_master: planned bus transfers with driver/monitor processes.
// Depends on ibm_pkg (payload structs, item kinds, sequencer phases, roles) and the RTL top level.
// Prediction runs beside the block on every accepted request transaction.

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ibm_pkg::*;

   localparam int         BUF_DEPTH = 8;
   localparam logic [1:0] KIND_NONE = 2'd3;   // unused kind, block must ignore it

   // ---------------------------------------------------------------------
   // DUT hookup; every input starts from a known value
   // ---------------------------------------------------------------------
   logic       clock;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [3:0] csr_data  = '0;

   i2c_bitbang_master #(.BUFFER_DEPTH(BUF_DEPTH)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Bookkeeping shared by stimulus, driver and monitor
   // ---------------------------------------------------------------------
   req_type req_backlog [$];   // request transactions not yet put on the port
   rsp_type drive_fifo  [$];   // line drives and status the block still owes
   int      unaccepted = 0;    // queued or on the port, not yet taken
   int      send_idle  = 0;    // percent of cycles the sender holds back
   int      rsp_idle   = 0;    // percent of cycles the receiver stalls
   int      errors     = 0;
   int      n_accepted = 0;
   int      n_done     = 0;
   int      n_ok       = 0;
   int      n_rbytes   = 0;
   bit      mid_xfer   = 1'b0; // bus known busy: stray commands are safe to inject

   // ---------------------------------------------------------------------
   // Shadow of the sequencer. Mirrors reset values; reset is never reapplied.
   // Drive bits are stored exactly as the block reports them.
   // ---------------------------------------------------------------------
   logic [3:0] retry_cfg  = RETRY_RESET;
   logic [7:0] wbuf [BUF_DEPTH];
   int         fill_ptr   = 0;
   int         byte_idx   = 0;
   phase_type  seq_ph     = PH_IDLE;
   role_type   cur_role   = ROLE_SEL;
   logic [3:0] bit_cnt    = '0;
   logic [3:0] bytes_left = '0;
   logic [3:0] tries_left = '0;
   logic [7:0] shreg      = '0;
   logic [7:0] dev_byte   = '0;
   logic [7:0] reg_byte   = '0;
   logic       rd_xfer    = 1'b0;
   logic       scl_low    = 1'b0;
   logic       sda_low    = 1'b0;

   function automatic void shift_out(input logic [7:0] v);
      shreg   = v;
      bit_cnt = '0;
      seq_ph  = PH_TB0;
   endfunction

   // entries past the buffer go out as zero
   function automatic void shift_out_data();
      shift_out((byte_idx < BUF_DEPTH) ? wbuf[byte_idx] : 8'h00);
   endfunction

   // One request in, one result out; advances the shadow state.
   function automatic rsp_type i2c_advance(input req_type r);
      rsp_type    o;
      logic [3:0] cnt;
      logic       ack;
      o = '0;
      case (r.kind)
         KIND_LOAD: begin
            if (seq_ph == PH_IDLE && fill_ptr < BUF_DEPTH) begin
               wbuf[fill_ptr] = r.write_byte;
               fill_ptr++;
            end
         end
         KIND_START: begin
            if (seq_ph == PH_IDLE) begin
               cnt      = r.byte_count;
               fill_ptr = 0;
               dev_byte = r.device_address;
               reg_byte = r.start_address;
               rd_xfer  = r.is_read;
               if (!rd_xfer && cnt > BUF_DEPTH) cnt = 4'(BUF_DEPTH);
               bytes_left = cnt;
               if (cnt == 0) begin
                  o.done_res = 1'b1;
               end else begin
                  tries_left = (retry_cfg == 0) ? 4'd1 : retry_cfg;
                  cur_role   = ROLE_SEL;
                  byte_idx   = 0;
                  seq_ph     = PH_ST0;
               end
            end
         end
         KIND_TICK: begin
            case (seq_ph)
               PH_ST0: begin sda_low = 1'b0; seq_ph = PH_ST1; end
               PH_ST1: begin scl_low = 1'b0; seq_ph = PH_ST2; end
               PH_ST2: begin sda_low = 1'b1; seq_ph = PH_ST3; end
               PH_ST3: begin
                  scl_low = 1'b1;
                  shift_out((cur_role == ROLE_RSEL) ? (dev_byte | 8'h01) : dev_byte);
               end
               PH_TB0: begin
                  scl_low = 1'b1;
                  sda_low = ~shreg[7];
                  seq_ph  = PH_TB1;
               end
               PH_TB1: begin scl_low = 1'b0; seq_ph = PH_TB2; end
               PH_TB2: begin
                  scl_low = 1'b1;
                  shreg   = {shreg[6:0], 1'b0};
                  bit_cnt = bit_cnt + 4'd1;
                  seq_ph  = (bit_cnt >= 4'd8) ? PH_TA0 : PH_TB0;
               end
               PH_TA0: begin sda_low = 1'b0; seq_ph = PH_TA1; end
               PH_TA1: begin scl_low = 1'b0; seq_ph = PH_TA2; end
               PH_TA2: begin
                  scl_low = 1'b1;
                  ack     = ~r.sda_sample;
                  if (cur_role == ROLE_SEL) begin
                     if (ack) begin
                        cur_role = ROLE_ADR;
                        shift_out(reg_byte);
                     end else begin
                        tries_left = tries_left - 4'd1;
                        seq_ph     = (tries_left != 0) ? PH_ST0 : PH_SP0;
                     end
                  end else if (!ack) begin
                     seq_ph = PH_SP0;
                  end else if (cur_role == ROLE_ADR) begin
                     if (rd_xfer) begin
                        cur_role = ROLE_RSEL;
                        seq_ph   = PH_ST0;
                     end else begin
                        cur_role = ROLE_DATA;
                        byte_idx = 0;
                        shift_out_data();
                     end
                  end else if (cur_role == ROLE_DATA) begin
                     bytes_left = bytes_left - 4'd1;
                     byte_idx++;
                     if (bytes_left == 0) seq_ph = PH_SP0;
                     else shift_out_data();
                  end else begin
                     shreg   = '0;
                     bit_cnt = '0;
                     seq_ph  = PH_RXH;
                  end
               end
               PH_RXH: begin scl_low = 1'b0; sda_low = 1'b0; seq_ph = PH_RXL; end
               PH_RXL: begin
                  scl_low = 1'b1;
                  shreg   = {shreg[6:0], r.sda_sample};
                  bit_cnt = bit_cnt + 4'd1;
                  if (bit_cnt >= 4'd8) begin
                     bytes_left = bytes_left - 4'd1;
                     seq_ph     = PH_RK0;
                  end else begin
                     seq_ph = PH_RXH;
                  end
               end
               PH_RK0: begin sda_low = (bytes_left != 0); seq_ph = PH_RK1; end
               PH_RK1: begin scl_low = 1'b0; seq_ph = PH_RK2; end
               PH_RK2: begin
                  scl_low      = 1'b1;
                  sda_low      = 1'b0;
                  o.read_data  = shreg;
                  o.read_valid = 1'b1;
                  if (bytes_left == 0) begin
                     seq_ph = PH_SP0;
                  end else begin
                     shreg   = '0;
                     bit_cnt = '0;
                     seq_ph  = PH_RXH;
                  end
               end
               PH_SP0: begin scl_low = 1'b1; sda_low = 1'b1; seq_ph = PH_SP1; end
               PH_SP1: begin scl_low = 1'b0; seq_ph = PH_SP2; end
               PH_SP2: begin
                  sda_low    = 1'b0;
                  o.done_res = 1'b1;
                  o.success  = (bytes_left == 0);
                  seq_ph     = PH_IDLE;
               end
               default: begin   // idle tick: both lines released
                  scl_low = 1'b0;
                  sda_low = 1'b0;
                  seq_ph  = PH_IDLE;
               end
            endcase
         end
         default: ;   // unused kind: no effect
      endcase
      o.scl_drive_low = scl_low;
      o.sda_drive_low = sda_low;
      o.busy_res      = (seq_ph != PH_IDLE);
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: one request transaction per accepted edge, fed from the backlog.
   // A stalled transaction holds; otherwise valid is decided by the idle mix.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : driver
      rsp_type want;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            want = i2c_advance(req_data);
            drive_fifo.push_back(want);
            unaccepted--;
            n_accepted++;
            n_done   += want.done_res;
            n_ok     += want.success;
            n_rbytes += want.read_valid;
         end
         if (!(req_valid && req_stall)) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle) begin
               req_data  <= req_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: in-order compare of every accepted result transaction
   // ---------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [7:0] want_v,
                                       input logic [7:0] got_v);
      if (got_v !== want_v) begin
         $error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (drive_fifo.size() == 0) begin
               $error("result %h arrived with nothing outstanding", rsp_data);
               errors++;
            end else begin
               want = drive_fifo.pop_front();
               check_field("scl_drive_low", 8'(want.scl_drive_low),
                           8'(rsp_data.scl_drive_low));
               check_field("sda_drive_low", 8'(want.sda_drive_low),
                           8'(rsp_data.sda_drive_low));
               check_field("read_data",     want.read_data,     rsp_data.read_data);
               check_field("read_valid",    8'(want.read_valid), 8'(rsp_data.read_valid));
               check_field("busy_res",      8'(want.busy_res),   8'(rsp_data.busy_res));
               check_field("done_res",      8'(want.done_res),   8'(rsp_data.done_res));
               check_field("success",       8'(want.success),    8'(rsp_data.success));
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_idle);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers. Transfers are planned from bus timing: start 4 ticks,
   // byte out 24, ACK slot 3 (sample used on its last tick), byte in 19
   // (8 x 2 plus master ACK), stop 3.
   // ---------------------------------------------------------------------
   task automatic issue(input req_type r);
      req_backlog.push_back(r);
      unaccepted++;
   endtask

   function automatic req_type any_req(input logic [1:0] k);
      req_type r;
      r      = req_type'($urandom);
      r.kind = k;
      return r;
   endfunction

   // one tick; mid-transfer, sometimes preceded by a command the block must ignore
   task automatic bus_tick(input logic s);
      req_type    r;
      logic [1:0] k;
      if (mid_xfer && $urandom_range(99) < 6) begin
         case ($urandom_range(2))
            0:       k = KIND_LOAD;
            1:       k = KIND_START;
            default: k = KIND_NONE;
         endcase
         issue(any_req(k));
      end
      r            = any_req(KIND_TICK);
      r.sda_sample = s;
      issue(r);
   endtask

   task automatic free_ticks(input int n);
      repeat (n) bus_tick(1'($urandom));
   endtask

   // sel_nacks: device-select NACKs before an ACK (>= tries gives up).
   // nack_stage: 0 register byte, then data byte n (write) or device|1 (read, 1);
   // negative for none.
   task automatic run_xfer(input logic [7:0] dev, input logic [7:0] regad,
                           input logic [3:0] cnt, input logic rd,
                           input int sel_nacks, input int nack_stage);
      req_type r;
      int      tries;
      int      nbytes;
      tries            = (retry_cfg == 0) ? 1 : int'(retry_cfg);
      nbytes           = (!rd && cnt > BUF_DEPTH) ? BUF_DEPTH : int'(cnt);
      r                = any_req(KIND_START);
      r.device_address = dev;
      r.start_address  = regad;
      r.byte_count     = cnt;
      r.is_read        = rd;
      issue(r);
      if (cnt == 0) return;
      mid_xfer = 1'b1;
      for (int i = 0; i < sel_nacks && i < tries; i++) begin
         free_ticks(30);
         bus_tick(1'b1);
      end
      if (sel_nacks < tries) begin
         free_ticks(30);
         bus_tick(1'b0);
         free_ticks(26);
         bus_tick(nack_stage == 0);
         if (nack_stage != 0) begin
            if (rd) begin
               free_ticks(30);           // repeated start plus device|1
               bus_tick(nack_stage == 1);
               if (nack_stage != 1) free_ticks(19 * nbytes);
            end else begin
               for (int b = 1; b <= nbytes && (nack_stage < 1 || b <= nack_stage); b++) begin
                  free_ticks(26);
                  bus_tick(nack_stage == b);
               end
            end
         end
      end
      free_ticks(3);                     // stop
      mid_xfer = 1'b0;
   endtask

   // mostly short, well-formed transfers; a few zero-count ones, longer reads or oversized writes
   task automatic random_xfer();
      logic       rd;
      logic [3:0] cnt;
      int         nbytes;
      int         nacks;
      int         stage;
      int         pick;
      rd   = 1'($urandom);
      pick = $urandom_range(99);
      if (pick < 6)       cnt = 4'd0;
      else if (pick < 12) cnt = rd ? 4'($urandom_range(5, 8)) : 4'($urandom_range(9, 15));
      else                cnt = 4'($urandom_range(1, 3));
      nbytes = (!rd && cnt > BUF_DEPTH) ? BUF_DEPTH : int'(cnt);
      nacks  = ($urandom_range(99) < 60) ? 0 : $urandom_range(1, 3);
      stage  = ($urandom_range(99) < 70) ? -1 : $urandom_range(0, rd ? 1 : nbytes);
      repeat ($urandom_range(0, BUF_DEPTH + 1)) issue(any_req(KIND_LOAD));
      run_xfer(8'($urandom), 8'($urandom), cnt, rd, nacks, stage);
      free_ticks($urandom_range(0, 2));
   endtask

   // sender holds off until every owed result is back, then a short settle
   task automatic wait_quiet();
      while (unaccepted != 0 || drive_fifo.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_retry(input logic [3:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      retry_cfg = v;
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : stim
      req_type    r;
      logic [3:0] next_retry;
      int         goal;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: reset retry limit, no idling
      free_ticks(2);                            // ticks on an idle bus
      for (int i = 0; i <= BUF_DEPTH; i++) begin
         r            = any_req(KIND_LOAD);
         r.write_byte = (i == BUF_DEPTH) ? 8'h5A : (i % 2 != 0) ? 8'hFF : 8'h00;
         issue(r);                              // last one lands on a full buffer
      end
      r = '1;                                   // unused kind, every field high
      issue(r);
      run_xfer(8'hFF, 8'hFF, 4'd0, 1'b0, 0, -1);   // zero count write
      run_xfer(8'h00, 8'h00, 4'd0, 1'b1, 0, -1);   // zero count read
      run_xfer(8'hFF, 8'h00, 4'd15, 1'b0, 0, 2);   // oversized write, NACK on byte 2
      wait_quiet();

      // random phases, each with its own retry limit and idle mix
      for (int p = 0; p < 4; p++) begin
         case (p)
            0:       begin next_retry = 4'd15; send_idle = 0;  rsp_idle = 0;  end
            1:       begin next_retry = 4'd1;  send_idle = 46; rsp_idle = 0;  end
            2:       begin next_retry = 4'd0;  send_idle = 0;  rsp_idle = 46; end
            default: begin
               next_retry = 4'($urandom_range(1, 15));
               send_idle  = 11;
               rsp_idle   = 11;
            end
         endcase
         wait_quiet();
         write_retry(next_retry);
         goal = n_accepted + unaccepted + 40;
         while (n_accepted + unaccepted < goal) random_xfer();
      end

      wait_quiet();
      repeat (10) @(posedge clock);
      $display("Ran %0d request transactions: %0d bus transfers ended, %0d complete, %0d bytes read.",
               n_accepted, n_done, n_ok, n_rbytes);
      $display("Retry limits 10, 15, 1, 0 and %0d, under four sender/receiver idle mixes.",
               retry_cfg);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin : watchdog
      #2_000_000;
      $display("Timed out with %0d results still owed", drive_fifo.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
